[design/lfuc_pkg.sv]
// Shared types and constants for the LFU cache with LRU tie-break.
package lfuc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_out_item;

endpackage

[design/lfuc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lfuc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/lfu_cache_lru_tiebreak_core.sv]
// LFU cache with LRU tie-break: a sequencer sweeps the entry RAM one slot per cycle.
// A get miss or a put at zero capacity takes one sweep; every other transaction takes two:
// one sweep finds the match, the victim and the free slot, a second sweep ages the ranks.
// The next transaction is taken only in the idle state after the result is loaded, so the
// block cannot take a new transaction while one is in flight; a stalled result holds it longer.
// Reset clears the valid bits and occupancy and sets the capacity to 16;
// there is no clearing pass, so the first item is taken in the cycle after reset.
module lfu_cache_lru_tiebreak_core #(
    parameter int ENTRIES    = lfuc_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfuc_pkg::DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lfuc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfuc_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lfuc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int REC_W  = 64 + COUNT_BITS + RANK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    t_state                  r_state;
    logic [ENTRIES-1:0]      r_valid;
    logic [OCC_W-1:0]        r_occ;
    logic [CAP_W-1:0]        r_cap;
    t_in_item                r_item;
    logic [IDX_W:0]          r_cnt;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_live;

    logic                    r_found;
    logic [IDX_W-1:0]        r_fidx;
    logic [RANK_W-1:0]       r_frank;
    logic [31:0]             r_fdata;
    logic [COUNT_BITS-1:0]   r_fcount;

    logic                    r_vic_any;
    logic [IDX_W-1:0]        r_vidx;
    logic [RANK_W-1:0]       r_vrank;
    logic [31:0]             r_vkey;
    logic [COUNT_BITS-1:0]   r_vcount;

    logic                    r_free_any;
    logic [IDX_W-1:0]        r_free_idx;

    logic [IDX_W-1:0]        r_target;
    logic [RANK_W-1:0]       r_thr;
    logic                    r_age_all;
    logic                    r_grow;
    logic [REC_W-1:0]        r_new_rec;

    t_out_item               r_res;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic                    cnt_live;
    logic                    cfg_wr;
    logic                    full;
    logic                    cap_zero;
    logic [REC_W-1:0]        ram_q;
    logic [31:0]             q_key;
    logic [31:0]             q_data;
    logic [COUNT_BITS-1:0]   q_count;
    logic [RANK_W-1:0]       q_rank;
    logic                    q_valid;
    logic [COUNT_BITS-1:0]   f_count_inc;
    logic                    ram_we;
    logic [REC_W-1:0]        ram_wdata;
    logic                    is_target;

    assign cnt_live = (32'(r_cnt) < ENTRIES);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, r_cap} : 32'd0;

    // Capacity above the table size behaves as the table size.
    assign full     = (32'(r_occ) >= 32'(r_cap)) || (32'(r_occ) >= ENTRIES);
    assign cap_zero = (r_cap == '0);

    assign q_key   = ram_q[REC_W-1 -: 32];
    assign q_data  = ram_q[REC_W-33 -: 32];
    assign q_count = ram_q[RANK_W +: COUNT_BITS];
    assign q_rank  = ram_q[RANK_W-1:0];
    assign q_valid = r_valid[r_rd_idx];

    assign f_count_inc = (r_fcount == {COUNT_BITS{1'b1}}) ? r_fcount
                                                          : r_fcount + 1'b1;

    // During the update sweep every valid entry ages by one if it is more recent than the
    // threshold or the put fills a free slot; victim removal plus reinsertion reduces to this.
    assign is_target = (r_rd_idx == r_target);
    assign ram_we    = (r_state == ST_UPDATE) && r_rd_live &&
                       (is_target || (q_valid && (r_age_all || (q_rank < r_thr))));
    assign ram_wdata = is_target ? r_new_rec
                                 : {q_key, q_data, q_count, q_rank + 1'b1};

    lfuc_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item     <= i_in_item;
                        r_cnt      <= '0;
                        r_rd_live  <= 1'b0;
                        r_found    <= 1'b0;
                        r_vic_any  <= 1'b0;
                        r_free_any <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end

                ST_SCAN: begin
                    if (cnt_live) begin
                        r_rd_idx <= r_cnt[IDX_W-1:0];
                        r_cnt    <= r_cnt + 1'b1;
                    end
                    r_rd_live <= cnt_live;

                    if (r_rd_live) begin
                        if (q_valid && (q_key == r_item.key) && !r_found) begin
                            r_found  <= 1'b1;
                            r_fidx   <= r_rd_idx;
                            r_frank  <= q_rank;
                            r_fdata  <= q_data;
                            r_fcount <= q_count;
                        end
                        if (q_valid && (!r_vic_any || (q_count < r_vcount) ||
                                        ((q_count == r_vcount) && (q_rank > r_vrank)))) begin
                            r_vic_any <= 1'b1;
                            r_vidx    <= r_rd_idx;
                            r_vrank   <= q_rank;
                            r_vkey    <= q_key;
                            r_vcount  <= q_count;
                        end
                        if (!q_valid && !r_free_any) begin
                            r_free_any <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end else if (!cnt_live) begin
                        r_cnt <= '0;
                        if (r_item.kind == KIND_GET) begin
                            if (r_found) begin
                                r_target  <= r_fidx;
                                r_thr     <= r_frank;
                                r_age_all <= 1'b0;
                                r_grow    <= 1'b0;
                                r_new_rec <= {r_item.key, r_fdata, f_count_inc,
                                              {RANK_W{1'b0}}};
                                r_res     <= {1'b1, r_fdata, 1'b0, 32'd0};
                                r_state   <= ST_UPDATE;
                            end else begin
                                r_res   <= {1'b0, MISS_VALUE, 1'b0, 32'd0};
                                r_state <= ST_FINISH;
                            end
                        end else if (cap_zero) begin
                            r_res   <= '0;
                            r_state <= ST_FINISH;
                        end else if (r_found) begin
                            r_target  <= r_fidx;
                            r_thr     <= r_frank;
                            r_age_all <= 1'b0;
                            r_grow    <= 1'b0;
                            r_new_rec <= {r_item.key, r_item.value, f_count_inc,
                                          {RANK_W{1'b0}}};
                            r_res     <= {1'b1, 32'd0, 1'b0, 32'd0};
                            r_state   <= ST_UPDATE;
                        end else if (full && r_vic_any) begin
                            r_target  <= r_vidx;
                            r_thr     <= r_vrank;
                            r_age_all <= 1'b0;
                            r_grow    <= 1'b0;
                            r_new_rec <= {r_item.key, r_item.value,
                                          COUNT_BITS'(1), {RANK_W{1'b0}}};
                            r_res     <= {1'b0, 32'd0, 1'b1, r_vkey};
                            r_state   <= ST_UPDATE;
                        end else begin
                            r_target  <= r_free_idx;
                            r_thr     <= '0;
                            r_age_all <= 1'b1;
                            r_grow    <= 1'b1;
                            r_new_rec <= {r_item.key, r_item.value,
                                          COUNT_BITS'(1), {RANK_W{1'b0}}};
                            r_res     <= '0;
                            r_state   <= ST_UPDATE;
                        end
                    end
                end

                ST_UPDATE: begin
                    if (cnt_live) begin
                        r_rd_idx <= r_cnt[IDX_W-1:0];
                        r_cnt    <= r_cnt + 1'b1;
                    end
                    r_rd_live <= cnt_live;

                    if (!cnt_live && !r_rd_live) begin
                        r_valid[r_target] <= 1'b1;
                        if (r_grow) begin
                            r_occ <= r_occ + 1'b1;
                        end
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
